### rtl/siq_pkg.sv
// ============================================================================
// siq_pkg: speculative instruction queue package
// Entry layout, stream payload layouts, operation and status codes, cell commands and controller states.
// ============================================================================
package siq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;
	localparam int unsigned SEQ_W           = 6;
	localparam int unsigned LVL_W           = 3;
	localparam int unsigned WORD_W          = 32;
	localparam int unsigned CNT_OUT_W       = 5;

	// operation selector carried on s_tuser
	typedef enum logic [2:0] {
		MODE_INSERT     = 3'd0,
		MODE_POP        = 3'd1,
		MODE_FREE_SEQ   = 3'd2,
		MODE_FREE_LVL   = 3'd3,
		MODE_REMOVE_DEP = 3'd4,
		MODE_FLUSH_ALL  = 3'd5,
		MODE_FLUSH_LVL  = 3'd6
	} mode_t;

	// result status carried on m_tuser
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2
	} status_t;

	// broadcast command to the cell row
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_LOAD,
		CMD_POP,
		CMD_FREE_SEQ,
		CMD_FREE_LVL,
		CMD_MARK_DEP,
		CMD_MARK_LVL,
		CMD_COMPACT
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_COMPACT
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0] target;
		logic              pred_taken;
		logic              is_branch;
		logic [SEQ_W-1:0]  dep_seq;
		logic              dep_valid;
		logic [LVL_W-1:0]  level;
		logic [SEQ_W-1:0]  seq;
		logic [WORD_W-1:0] inst;
		logic [WORD_W-1:0] addr;
	} entry_t;

	typedef struct packed {
		cell_cmd_t        cmd;
		logic [SEQ_W-1:0] arg_seq;
		logic [LVL_W-1:0] arg_level;
	} cell_ctrl_t;

	// s_tdata layout, lowest field last
	typedef struct packed {
		logic [4:0]       pad;
		logic [LVL_W-1:0] arg_level;
		logic [SEQ_W-1:0] arg_seq;
		entry_t           entry;
	} in_payload_t;

	// m_tdata layout, lowest field last
	typedef struct packed {
		logic                 pad;
		entry_t               head;
		logic [CNT_OUT_W-1:0] count;
	} out_payload_t;

endpackage

### rtl/siq_cell.sv
// ============================================================================
// siq_cell: one queue slot
// Holds one entry and a removal mark; takes its neighbor's slot on a shift.
// ============================================================================
module siq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  siq_pkg::cell_ctrl_t ctrl,
	input  siq_pkg::entry_t     load_data,
	input  logic                sel_load,    // this slot is the tail
	input  logic                occupied,
	input  siq_pkg::entry_t     next_entry,
	input  logic                next_kill,   // removal mark of the neighbor slot
	input  logic                kill_prefix, // a slot nearer the head is marked
	output siq_pkg::entry_t     entry,
	output logic                kill,        // this slot's own removal mark
	output logic                kill_chain
);

	siq_pkg::entry_t entry_q;
	logic            kill_q;
	logic            dep_hit;
	logic            lvl_over;
	logic            shift_en;

	always_comb begin
		dep_hit  = entry_q.dep_valid && (entry_q.dep_seq == ctrl.arg_seq);
		lvl_over = entry_q.level > ctrl.arg_level;
		shift_en = (ctrl.cmd == siq_pkg::CMD_POP) ||
			((ctrl.cmd == siq_pkg::CMD_COMPACT) && (kill_prefix || kill_q));
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.cmd) inside
			siq_pkg::CMD_LOAD: begin
				if (sel_load) entry_q <= load_data;
			end
			siq_pkg::CMD_FREE_SEQ: begin
				if (entry_q.seq > ctrl.arg_seq) entry_q.seq <= entry_q.seq - 1'b1;
				if (entry_q.dep_valid && (entry_q.dep_seq > ctrl.arg_seq))
					entry_q.dep_seq <= entry_q.dep_seq - 1'b1;
			end
			siq_pkg::CMD_FREE_LVL: begin
				if (lvl_over) entry_q.level <= entry_q.level - 1'b1;
			end
			siq_pkg::CMD_MARK_LVL: begin
				// survivor of a level flush loses its tie to the resolved branch
				if (occupied && !lvl_over && dep_hit) entry_q.dep_valid <= 1'b0;
			end
			siq_pkg::CMD_POP, siq_pkg::CMD_COMPACT: begin
				if (shift_en) entry_q <= next_entry;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kill_q <= 1'b0;
		end else begin
			unique case (ctrl.cmd)
				siq_pkg::CMD_MARK_DEP: kill_q <= occupied && dep_hit;
				siq_pkg::CMD_MARK_LVL: kill_q <= occupied && lvl_over;
				siq_pkg::CMD_COMPACT: begin
					if (shift_en) kill_q <= next_kill;
				end
				default: begin
				end
			endcase
		end
	end

	assign entry      = entry_q;
	assign kill       = kill_q;
	assign kill_chain = kill_prefix || kill_q;

endmodule

### rtl/speculative_instruction_queue.sv
// ============================================================================
// speculative_instruction_queue: in-order instruction queue with squash
// Row of slot cells kept compacted at the head, one result item per op.
// ============================================================================
// One operation enters per item on the slave stream (mode on s_tuser) and one
// result item leaves on the master stream (status on m_tuser). The queue is a
// row of QUEUE_DEPTH cells with the head in cell 0; a pop shifts every cell one
// place toward the head at the accepting edge, an insert loads the cell at the
// tail. Insert, pop, renumbering of sequence numbers or levels, and flush-all
// post their result directly: it is registered at the accepting edge. The two
// selective squashes (remove dependents, flush by level) go through a compaction
// state: the accepting edge marks victims in each cell, then each cycle the
// cells from the first marked slot onward take their neighbor's slot, removing
// one victim, and a final cycle with no marks left posts the result. The output
// register holds one result; a new item is taken while the queue is idle and
// that register is empty or being drained the same cycle.
// Entry fields after reset are unknown until an insert writes them; only
// occupied slots are ever reported.
module speculative_instruction_queue #(
	parameter int unsigned QUEUE_DEPTH = siq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// addr, inst, seq_num, branch_level, dep_valid, dep_seq, is_branch,
	// pred_taken, branch_target, arg_seq, arg_level, zero pad
	input  logic [127:0] s_tdata,
	input  logic [2:0]   s_tuser,   // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	// count, head_addr, head_inst, head_seq, head_level, head_dep_valid,
	// head_dep_seq, head_is_branch, head_pred_taken, head_target, zero pad
	output logic [119:0] m_tdata,
	output logic [1:0]   m_tuser    // status
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	siq_pkg::in_payload_t  in_pl;
	siq_pkg::mode_t        mode;
	siq_pkg::state_t       state_q, state_d;
	siq_pkg::cell_ctrl_t   ctrl;
	siq_pkg::entry_t       cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH:0]  kill_chain;   // kill_chain[i] feeds cell i
	logic [QUEUE_DEPTH-1:0] kill_mark;   // each cell's own removal mark
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  any_kill;
	logic                  squash_mode;

	// result register
	logic                  out_valid_q;
	siq_pkg::status_t      out_status_q;
	siq_pkg::out_payload_t out_pl_q;
	logic                  post_result;
	siq_pkg::status_t      res_status;
	siq_pkg::entry_t       res_head;

	assign in_pl       = siq_pkg::in_payload_t'(s_tdata);
	assign mode        = siq_pkg::mode_t'(s_tuser);
	assign accept      = s_tvalid && s_tready;
	assign full        = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign empty       = cnt_q == '0;
	assign any_kill    = kill_chain[QUEUE_DEPTH];
	assign squash_mode = (mode == siq_pkg::MODE_REMOVE_DEP) ||
		(mode == siq_pkg::MODE_FLUSH_LVL);

	// ---------------------------------------------------------------- cell row
	assign kill_chain[0] = 1'b0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		siq_pkg::entry_t nxt_entry;
		logic            nxt_kill;

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt_entry = cell_entry[i];
			assign nxt_kill  = 1'b0;
		end else begin : g_mid
			assign nxt_entry = cell_entry[i+1];
			assign nxt_kill  = kill_mark[i+1];
		end

		siq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.load_data   (in_pl.entry),
			.sel_load    (cnt_q == CNT_W'(i)),
			.occupied    (CNT_W'(i) < cnt_q),
			.next_entry  (nxt_entry),
			.next_kill   (nxt_kill),
			.kill_prefix (kill_chain[i]),
			.entry       (cell_entry[i]),
			.kill        (kill_mark[i]),
			.kill_chain  (kill_chain[i+1])
		);
	end

	// ------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			siq_pkg::ST_IDLE: begin
				if (accept && squash_mode) state_d = siq_pkg::ST_COMPACT;
			end
			siq_pkg::ST_COMPACT: begin
				if (!any_kill) state_d = siq_pkg::ST_IDLE;
			end
			default: state_d = siq_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------- control outputs
	always_comb begin
		s_tready       = 1'b0;
		ctrl.cmd       = siq_pkg::CMD_HOLD;
		ctrl.arg_seq   = in_pl.arg_seq;
		ctrl.arg_level = in_pl.arg_level;
		cnt_d          = cnt_q;
		post_result    = 1'b0;
		res_status     = siq_pkg::STAT_OK;
		res_head       = '0;
		unique case (state_q)
			siq_pkg::ST_IDLE: begin
				s_tready = !out_valid_q || m_tready;
				if (accept) begin
					post_result = !squash_mode;
					unique case (mode)
						siq_pkg::MODE_INSERT: begin
							if (full) begin
								res_status = siq_pkg::STAT_FULL;
							end else begin
								ctrl.cmd = siq_pkg::CMD_LOAD;
								cnt_d    = cnt_q + 1'b1;
							end
						end
						siq_pkg::MODE_POP: begin
							if (empty) begin
								res_status = siq_pkg::STAT_EMPTY;
							end else begin
								ctrl.cmd = siq_pkg::CMD_POP;
								cnt_d    = cnt_q - 1'b1;
								res_head = cell_entry[0];
							end
						end
						siq_pkg::MODE_FREE_SEQ:   ctrl.cmd = siq_pkg::CMD_FREE_SEQ;
						siq_pkg::MODE_FREE_LVL:   ctrl.cmd = siq_pkg::CMD_FREE_LVL;
						siq_pkg::MODE_REMOVE_DEP: ctrl.cmd = siq_pkg::CMD_MARK_DEP;
						siq_pkg::MODE_FLUSH_LVL:  ctrl.cmd = siq_pkg::CMD_MARK_LVL;
						siq_pkg::MODE_FLUSH_ALL:  cnt_d    = '0;
						default: begin
						end
					endcase
				end
			end
			siq_pkg::ST_COMPACT: begin
				ctrl.cmd = siq_pkg::CMD_COMPACT;
				if (any_kill) begin
					cnt_d = cnt_q - 1'b1;
				end else begin
					post_result = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// --------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= siq_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (post_result) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (post_result) begin
			out_status_q   <= res_status;
			out_pl_q.pad   <= 1'b0;
			out_pl_q.head  <= res_head;
			out_pl_q.count <= siq_pkg::CNT_OUT_W'(cnt_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pl_q;
	assign m_tuser  = out_status_q;

	// -------------------------------------------------------------- assertions
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_idle_no_marks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == siq_pkg::ST_IDLE |-> kill_mark == '0)
		else $error("removal marks left while idle");

	a_compact_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == siq_pkg::ST_COMPACT |-> !s_tready)
		else $error("input taken during compaction");

	a_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !squash_mode) |=> m_tvalid)
		else $error("single-cycle op did not post a result");

endmodule

### tb/speculative_instruction_queue_tb.sv
// ============================================================================
// speculative_instruction_queue_tb: self-checking bench for the instruction queue
// A table of directed operations, then about 500 random ones, drives the slave
// stream with random gaps while the master side stalls at random. A shadow
// queue in the bench predicts every result item the script does not type out,
// and each result is compared field by field in arrival order.
// ============================================================================
module speculative_instruction_queue_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH       = siq_pkg::QUEUE_DEPTH_DEF;
	// the mode encoding has one spare code; the queue must treat it as a no-op
	localparam logic [2:0]  MODE_UNUSED = 3'd7;
	localparam int          RANDOM_OPS  = 500;
	// Cycles with no item accepted on either side before the run is declared hung.
	// Worst legal stretch: a long sender gap, a squash removing all 16 entries and a
	// long receiver stall, plus the drain pause; the limit leaves ample margin.
	localparam int          HANG_LIMIT  = 4000;
	localparam int          TAIL_CYCLES = 24;

	// expected status plus the result payload, one per accepted operation
	typedef struct packed {
		logic [1:0]            status;
		siq_pkg::out_payload_t payload;
	} outcome_t;

	// one line of the directed script; reps > 1 issues a run of inserts whose
	// fields step with the repetition index
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] addr;
		logic [31:0] inst;
		logic [5:0]  seq;
		logic [2:0]  lvl;
		logic        dv;
		logic [5:0]  ds;
		logic        br;
		logic        pt;
		logic [31:0] tgt;
		logic [5:0]  aseq;
		logic [2:0]  alvl;
		logic [4:0]  reps;
		logic        typed;  // expected status/count typed below, head fields zero
		logic [1:0]  st;
		logic [4:0]  cnt;
	} step_row_t;

	localparam step_row_t SCRIPT [22] = '{
		// pop on empty right after reset
		'{siq_pkg::MODE_POP, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0, 32'h0,
			6'd0, 3'd0, 5'd1, 1'b1, siq_pkg::STAT_EMPTY, 5'd0},
		// spare mode code does nothing
		'{MODE_UNUSED, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0, 32'h0,
			6'd63, 3'd7, 5'd1, 1'b1, siq_pkg::STAT_OK, 5'd0},
		// all-ones and all-zeros entries
		'{siq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 3'd7, 1'b1,
			6'd63, 1'b1, 1'b1, 32'hFFFF_FFFF, 6'd0, 3'd0, 5'd1, 1'b1,
			siq_pkg::STAT_OK, 5'd1},
		'{siq_pkg::MODE_INSERT, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd63, 3'd7, 5'd1, 1'b1, siq_pkg::STAT_OK, 5'd2},
		'{siq_pkg::MODE_POP, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0, 32'h0,
			6'd0, 3'd0, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_POP, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0, 32'h0,
			6'd0, 3'd0, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		// fill to the brim: seq 8..23, levels cycle, every other entry dependent
		'{siq_pkg::MODE_INSERT, 32'h0000_1000, 32'h0000_0013, 6'd8, 3'd0, 1'b0,
			6'd20, 1'b0, 1'b0, 32'h0000_2000, 6'd0, 3'd0, 5'd16, 1'b0,
			siq_pkg::STAT_OK, 5'd0},
		// insert while full is rejected
		'{siq_pkg::MODE_INSERT, 32'hDEAD_BEEF, 32'hCAFE_F00D, 6'd1, 3'd1, 1'b1,
			6'd2, 1'b1, 1'b0, 32'h1234_5678, 6'd0, 3'd0, 5'd1, 1'b1,
			siq_pkg::STAT_FULL, 5'd16},
		'{siq_pkg::MODE_FREE_SEQ, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd63, 3'd0, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_FREE_SEQ, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd15, 3'd0, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_FREE_LVL, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd0, 3'd7, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_FREE_LVL, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd0, 3'd2, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_REMOVE_DEP, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd19, 3'd0, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_FLUSH_LVL, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd21, 3'd4, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_FREE_SEQ, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd0, 3'd0, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_FREE_LVL, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd0, 3'd0, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_POP, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0, 32'h0,
			6'd0, 3'd0, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_FLUSH_LVL, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd22, 3'd0, 5'd1, 1'b0, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_FLUSH_ALL, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd0, 3'd0, 5'd1, 1'b1, siq_pkg::STAT_OK, 5'd0},
		// squashes and pop on an empty queue
		'{siq_pkg::MODE_REMOVE_DEP, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd0, 3'd0, 5'd1, 1'b1, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_FLUSH_LVL, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0,
			32'h0, 6'd63, 3'd7, 5'd1, 1'b1, siq_pkg::STAT_OK, 5'd0},
		'{siq_pkg::MODE_POP, 32'h0, 32'h0, 6'd0, 3'd0, 1'b0, 6'd0, 1'b0, 1'b0, 32'h0,
			6'd0, 3'd0, 5'd1, 1'b1, siq_pkg::STAT_EMPTY, 5'd0}
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic [1:0]   m_tuser;

	// shadow of the queue contents, head at index 0
	siq_pkg::entry_t slots[$];
	// predicted result items not yet seen on the master stream
	outcome_t        awaited_results[$];
	int              mismatches = 0;
	int              stall_left = 0;
	int              idle_cycles = 0;
	bit              calm = 1'b0;  // stretch with no idling on either side

	speculative_instruction_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly back-to-back, sometimes a short gap, rarely a long pause
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Shadow queue update for one operation; returns the result it should produce.
	function automatic outcome_t apply_op(input logic [2:0] op,
			input siq_pkg::entry_t ent, input logic [5:0] aseq, input logic [2:0] alvl);
		outcome_t        res;
		siq_pkg::entry_t kept[$];
		siq_pkg::entry_t e;
		bit              dep;
		bit              drop;
		res = '0;
		case (op) inside
			siq_pkg::MODE_INSERT: begin
				if (slots.size() >= DEPTH)
					res.status = siq_pkg::STAT_FULL;
				else
					slots.push_back(ent);
			end
			siq_pkg::MODE_POP: begin
				if (slots.size() == 0)
					res.status = siq_pkg::STAT_EMPTY;
				else
					res.payload.head = slots.pop_front();
			end
			siq_pkg::MODE_FREE_SEQ: begin
				// freed number can't be held by anyone above it, so no wrap at zero
				foreach (slots[i]) begin
					if (slots[i].seq > aseq)
						slots[i].seq = slots[i].seq - 1'b1;
					if (slots[i].dep_valid && slots[i].dep_seq > aseq)
						slots[i].dep_seq = slots[i].dep_seq - 1'b1;
				end
			end
			siq_pkg::MODE_FREE_LVL: begin
				foreach (slots[i])
					if (slots[i].level > alvl)
						slots[i].level = slots[i].level - 1'b1;
			end
			siq_pkg::MODE_REMOVE_DEP, siq_pkg::MODE_FLUSH_LVL: begin
				// survivors keep their order; flush-by-level also resolves the branch
				foreach (slots[i]) begin
					e = slots[i];
					dep = e.dep_valid && (e.dep_seq == aseq);
					if (op == siq_pkg::MODE_FLUSH_LVL) begin
						drop = e.level > alvl;
						if (!drop && dep)
							e.dep_valid = 1'b0;
					end else begin
						drop = dep;
					end
					if (!drop)
						kept.push_back(e);
				end
				slots = kept;
			end
			siq_pkg::MODE_FLUSH_ALL: slots.delete();
			default: ;
		endcase
		res.payload.count = siq_pkg::CNT_OUT_W'(slots.size());
		return res;
	endfunction

	// random entry; half the time its dependency sequence is taken from a queued entry
	function automatic siq_pkg::entry_t random_entry();
		siq_pkg::entry_t e;
		int              k;
		e.addr       = $urandom;
		e.inst       = $urandom;
		e.target     = $urandom;
		e.seq        = 6'($urandom_range(0, 63));
		e.level      = 3'($urandom_range(0, 7));
		e.dep_valid  = 1'($urandom_range(0, 1));
		e.dep_seq    = 6'($urandom_range(0, 63));
		e.is_branch  = 1'($urandom_range(0, 1));
		e.pred_taken = 1'($urandom_range(0, 1));
		if (slots.size() != 0 && $urandom_range(0, 1)) begin
			k = $urandom_range(0, slots.size() - 1);
			e.dep_seq = slots[k].seq;
		end
		return e;
	endfunction

	// sequence operand: usually one that matches a queued entry so squashes bite
	function automatic logic [5:0] pick_seq_arg(input bit from_dep);
		int k;
		if (slots.size() != 0 && $urandom_range(0, 3) != 0) begin
			k = $urandom_range(0, slots.size() - 1);
			return from_dep ? slots[k].dep_seq : slots[k].seq;
		end
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic logic [2:0] pick_op(input int insert_pct);
		int roll;
		if ($urandom_range(0, 99) < insert_pct)
			return siq_pkg::MODE_INSERT;
		roll = $urandom_range(0, 99);
		if (roll < 40) return siq_pkg::MODE_POP;
		if (roll < 52) return siq_pkg::MODE_FREE_SEQ;
		if (roll < 64) return siq_pkg::MODE_FREE_LVL;
		if (roll < 76) return siq_pkg::MODE_REMOVE_DEP;
		if (roll < 88) return siq_pkg::MODE_FLUSH_LVL;
		if (roll < 94) return siq_pkg::MODE_FLUSH_ALL;
		return MODE_UNUSED;
	endfunction

	// Present one item, hold it until accepted, then log its expected result.
	// Called at a rising edge; valid stays high across back-to-back items.
	task automatic send_op(input logic [2:0] op, input siq_pkg::entry_t ent,
			input logic [5:0] aseq, input logic [2:0] alvl, input bit typed,
			input outcome_t fixed);
		siq_pkg::in_payload_t p;
		outcome_t             predicted;
		int                   gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p = '0;
		p.entry     = ent;
		p.arg_seq   = aseq;
		p.arg_level = alvl;
		s_tvalid <= 1'b1;
		s_tdata  <= p;
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_op(op, ent, aseq, alvl);
		awaited_results.push_back(typed ? fixed : predicted);
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected %h, got %h", name, want, seen);
			mismatches++;
		end
	endfunction

	task automatic check_result();
		outcome_t              want;
		siq_pkg::out_payload_t seen;
		if (awaited_results.size() == 0) begin
			$error("result item with no operation outstanding");
			mismatches++;
			return;
		end
		want = awaited_results.pop_front();
		seen = m_tdata;
		check_field("status", 32'(want.status), 32'(m_tuser));
		check_field("count", 32'(want.payload.count), 32'(seen.count));
		check_field("head_addr", want.payload.head.addr, seen.head.addr);
		check_field("head_inst", want.payload.head.inst, seen.head.inst);
		check_field("head_seq", 32'(want.payload.head.seq), 32'(seen.head.seq));
		check_field("head_level", 32'(want.payload.head.level),
			32'(seen.head.level));
		check_field("head_dep_valid", 32'(want.payload.head.dep_valid),
			32'(seen.head.dep_valid));
		check_field("head_dep_seq", 32'(want.payload.head.dep_seq),
			32'(seen.head.dep_seq));
		check_field("head_is_branch", 32'(want.payload.head.is_branch),
			32'(seen.head.is_branch));
		check_field("head_pred_taken", 32'(want.payload.head.pred_taken),
			32'(seen.head.pred_taken));
		check_field("head_target", want.payload.head.target, seen.head.target);
	endtask

	// Result side: check what is taken at this edge, then choose the next ready.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			check_result();
		if (stall_left == 0) begin
			m_tready   <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end
	end

	// Hang detector: any handshake on either stream counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		siq_pkg::entry_t ent;
		outcome_t        fixed;
		step_row_t       row;
		logic [2:0]      op;
		logic [5:0]      aseq;
		int              insert_pct;

		insert_pct = 50;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script. Runs of inserts step each field with the index so a
		// fill carries varied levels, dependencies and flags.
		foreach (SCRIPT[i]) begin
			row = SCRIPT[i];
			for (int r = 0; r < row.reps; r++) begin
				ent.addr       = row.addr + 32'(4 * r);
				ent.inst       = row.inst + 32'(r);
				ent.target     = row.tgt + 32'(r);
				ent.seq        = row.seq + 6'(r);
				ent.level      = row.lvl + 3'(r);
				ent.dep_valid  = row.dv ^ r[0];
				ent.dep_seq    = row.ds + 6'(r >> 2);
				ent.is_branch  = row.br ^ r[1];
				ent.pred_taken = row.pt ^ r[2];
				fixed = '0;
				fixed.status        = row.st;
				fixed.payload.count = row.cnt;
				send_op(row.op, ent, row.aseq, row.alvl, row.typed, fixed);
			end
		end

		// Random part. The insert share is redrawn every 40 operations so the queue
		// swings between nearly empty and full.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 3))
					0: insert_pct = 30;
					1: insert_pct = 50;
					2: insert_pct = 70;
					default: insert_pct = 85;
				endcase
			end
			if ($urandom_range(0, 49) == 0)
				calm = !calm;
			// sender holds off until every outstanding result has drained
			if (n == RANDOM_OPS / 2) begin
				s_tvalid <= 1'b0;
				do
					@(posedge clk);
				while (awaited_results.size() != 0);
			end
			op   = pick_op(insert_pct);
			ent  = random_entry();
			aseq = pick_seq_arg(op != siq_pkg::MODE_FREE_SEQ);
			send_op(op, ent, aseq, 3'($urandom_range(0, 7)), 1'b0, '0);
		end

		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
		// catch any stray result item the queue might still emit
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
